// ===== src/kbcon_pkg.sv =====
package kbcon_pkg;

	localparam int COORD_W = 12;
	localparam int CODE_W  = 8;
	localparam int CHAR_W  = 7;

	localparam logic [COORD_W-1:0] CUR_ORIGIN = COORD_W'(50);
	localparam logic [COORD_W-1:0] CELL_W     = COORD_W'(24);
	localparam logic [COORD_W-1:0] CELL_H     = COORD_W'(36);

	localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'h0E;
	localparam logic [CODE_W-1:0] CODE_ENTER     = 8'h1C;

	localparam logic [COORD_W-1:0] RESET_WIDTH  = COORD_W'(1024);
	localparam logic [COORD_W-1:0] RESET_HEIGHT = COORD_W'(768);
	// last cell column for the reset width: 50 + (40 - 1) * 24
	localparam logic [COORD_W-1:0] RESET_LAST_X = COORD_W'(986);

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_DRAW  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	// set-1 make code to ASCII, zero when the key is not mapped
	function automatic logic [CHAR_W-1:0] key_ascii(input logic [CHAR_W-1:0] code);
		logic [CHAR_W-1:0] ch;
		begin
			case (code)
				7'h02: ch = 7'h31;
				7'h03: ch = 7'h32;
				7'h04: ch = 7'h33;
				7'h05: ch = 7'h34;
				7'h06: ch = 7'h35;
				7'h07: ch = 7'h36;
				7'h08: ch = 7'h37;
				7'h09: ch = 7'h38;
				7'h0A: ch = 7'h39;
				7'h0B: ch = 7'h30;
				7'h10: ch = 7'h71;
				7'h11: ch = 7'h77;
				7'h12: ch = 7'h65;
				7'h13: ch = 7'h72;
				7'h14: ch = 7'h74;
				7'h15: ch = 7'h79;
				7'h16: ch = 7'h75;
				7'h17: ch = 7'h69;
				7'h18: ch = 7'h6F;
				7'h19: ch = 7'h70;
				7'h1E: ch = 7'h61;
				7'h1F: ch = 7'h73;
				7'h20: ch = 7'h64;
				7'h21: ch = 7'h66;
				7'h22: ch = 7'h67;
				7'h23: ch = 7'h68;
				7'h24: ch = 7'h6A;
				7'h25: ch = 7'h6B;
				7'h26: ch = 7'h6C;
				7'h2C: ch = 7'h7A;
				7'h2D: ch = 7'h78;
				7'h2E: ch = 7'h63;
				7'h2F: ch = 7'h76;
				7'h30: ch = 7'h62;
				7'h31: ch = 7'h6E;
				7'h32: ch = 7'h6D;
				7'h39: ch = 7'h20;
				default: ch = 7'h00;
			endcase
			return ch;
		end
	endfunction

endpackage

// ===== src/keyboard_text_console_cursor.sv =====
// Channel | Signals                                  | Transfer when
// --------+------------------------------------------+-------------------------
// in      | in_valid, in_ready, scancode             | in_valid & in_ready
// out     | out_valid, out_ready, action, char_code, | out_valid & out_ready
//         | cell_x, cell_y, scroll_up, cursor_*_px   |
// cfg     | cfg_wr_en, cfg_index, cfg_wdata          | cfg_wr_en (no wait)
//
// One scancode per cycle sustained while the output is not stalled; each item
// passes through the input register and then the result register, and its
// result is on the outputs once it is in the result register. The cursor
// registers update as the item moves into the result register.
// Reset (arst_n low) puts the cursor at (50,50), width 1024, height 768. A
// stalled output holds the result register and the input register, and
// in_ready drops only when both are full.
module keyboard_text_console_cursor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [kbcon_pkg::CODE_W-1:0]         scancode,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output kbcon_pkg::action_t                   action,
	output logic [kbcon_pkg::CHAR_W-1:0]         char_code,
	output logic [kbcon_pkg::COORD_W-1:0]        cell_x,
	output logic [kbcon_pkg::COORD_W-1:0]        cell_y,
	output logic                                 scroll_up,
	output logic [kbcon_pkg::COORD_W-1:0]        cursor_col_px,
	output logic [kbcon_pkg::COORD_W-1:0]        cursor_row_px,
	input  logic                                 cfg_wr_en,
	input  kbcon_pkg::cfg_reg_t                  cfg_index,
	input  logic [kbcon_pkg::COORD_W-1:0]        cfg_wdata
);
	import kbcon_pkg::*;

	// configuration
	logic [COORD_W-1:0] width_q;
	logic [COORD_W-1:0] height_q;
	logic [COORD_W-1:0] last_x_q;     // x of the last cell column
	logic               has_col_q;    // at least one full column fits

	// cursor state
	logic [COORD_W-1:0] cur_x_q;
	logic [COORD_W-1:0] cur_y_q;

	// input register
	logic               valid_s1;
	logic [CODE_W-1:0]  code_s1;

	// result register
	logic               valid_s2;
	action_t            action_s2;
	logic [CHAR_W-1:0]  char_s2;
	logic [COORD_W-1:0] cell_x_s2;
	logic [COORD_W-1:0] cell_y_s2;
	logic               scroll_s2;

	logic               advance;

	// last-column helper, evaluated on the width write
	logic [COORD_W:0]   wr_diff;
	logic [8:0]         wr_div8;
	logic [18:0]        wr_prod;
	logic [7:0]         wr_cols;
	logic [COORD_W:0]   wr_last;

	// next-state logic
	logic [CHAR_W-1:0]  ascii;
	logic               is_press;
	logic [COORD_W-1:0] nx_x;
	logic [COORD_W-1:0] nx_y;
	logic [COORD_W-1:0] ny_wrap;
	logic               wrap;
	action_t            nx_action;
	logic [CHAR_W-1:0]  nx_char;
	logic [COORD_W-1:0] nx_cell_x;
	logic [COORD_W-1:0] nx_cell_y;
	logic               nx_scroll;
	logic               newline;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// columns = (w - 50) / 24 = ((w - 50) >> 3) / 3, the /3 by reciprocal
	// 683 / 2048, exact for the nine-bit range. Last x = 26 + 24 * columns.
	always_comb begin
		wr_diff = {1'b0, cfg_wdata} - {1'b0, CUR_ORIGIN};
		wr_div8 = wr_diff[11:3];
		wr_prod = 19'(wr_div8) * 19'd683;
		wr_cols = wr_prod[18:11];
		wr_last = 13'd26 + ({5'd0, wr_cols} << 4) + ({5'd0, wr_cols} << 3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= RESET_WIDTH;
			height_q  <= RESET_HEIGHT;
			last_x_q  <= RESET_LAST_X;
			has_col_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH: begin
					width_q   <= cfg_wdata;
					last_x_q  <= wr_last[COORD_W-1:0];
					has_col_q <= !wr_diff[COORD_W] && (wr_cols != 8'd0);
				end
				REG_SCREEN_HEIGHT: begin
					height_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		ascii     = key_ascii(code_s1[CHAR_W-1:0]);
		is_press  = (code_s1 != '0) && !code_s1[CODE_W-1];
		nx_x      = cur_x_q;
		nx_y      = cur_y_q;
		nx_action = ACT_NONE;
		nx_char   = '0;
		nx_cell_x = '0;
		nx_cell_y = '0;
		nx_scroll = 1'b0;
		newline   = 1'b0;
		wrap      = ({1'b0, cur_x_q} + {1'b0, CELL_W}) > {1'b0, width_q};
		ny_wrap   = cur_y_q + CELL_H;

		if (is_press) begin
			if (code_s1 == CODE_BACKSPACE) begin
				if (cur_x_q == CUR_ORIGIN && cur_y_q == CUR_ORIGIN) begin
					// nothing left to delete
				end else if (cur_x_q > CUR_ORIGIN) begin
					nx_x      = cur_x_q - CELL_W;
					nx_action = ACT_CLEAR;
					nx_cell_x = nx_x;
					nx_cell_y = cur_y_q;
				end else if (cur_y_q > CUR_ORIGIN) begin
					// back to the line above, at its last column when one fits
					nx_y      = cur_y_q - CELL_H;
					if (has_col_q) begin
						nx_x = last_x_q;
					end
					nx_action = ACT_CLEAR;
					nx_cell_x = nx_x;
					nx_cell_y = nx_y;
				end
			end else if (code_s1 == CODE_ENTER) begin
				nx_x    = CUR_ORIGIN;
				nx_y    = ny_wrap;
				newline = 1'b1;
			end else if (ascii != '0) begin
				if (wrap) begin
					nx_x = CUR_ORIGIN;
					nx_y = ny_wrap;
				end
				nx_action = ACT_DRAW;
				nx_char   = ascii;
				nx_cell_x = nx_x;
				nx_cell_y = nx_y;
				nx_x      = nx_x + CELL_W;
				newline   = 1'b1;
			end

			// bottom check, once per item
			if (newline && (({1'b0, nx_y} + {1'b0, CELL_H}) > {1'b0, height_q})) begin
				nx_scroll = 1'b1;
				nx_y      = nx_y - CELL_H;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cur_x_q  <= CUR_ORIGIN;
			cur_y_q  <= CUR_ORIGIN;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				cur_x_q  <= nx_x;
				cur_y_q  <= nx_y;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= scancode;
		end
		if (advance) begin
			action_s2 <= nx_action;
			char_s2   <= nx_char;
			cell_x_s2 <= nx_cell_x;
			cell_y_s2 <= nx_cell_y;
			scroll_s2 <= nx_scroll;
		end
	end

	// cursor registers only change when a new result loads, so they serve
	// as the result's cursor fields
	assign out_valid     = valid_s2;
	assign action        = action_s2;
	assign char_code     = char_s2;
	assign cell_x        = cell_x_s2;
	assign cell_y        = cell_y_s2;
	assign scroll_up     = scroll_s2;
	assign cursor_col_px = cur_x_q;
	assign cursor_row_px = cur_y_q;

endmodule

// ===== tb/sv/keyboard_text_console_cursor_tb.sv =====
`timescale 1ns / 100ps

// Scancode-driven cursor console checker.
// The scoreboard class tracks its own copy of the cursor and the two screen
// registers, predicts one result per input transfer and compares each output
// transfer against the oldest prediction.
module keyboard_text_console_cursor_tb;
	import kbcon_pkg::*;

	// no transfer on either channel for this many cycles means a hang;
	// worst honest stall is a sender burst plus a receiver burst plus a drain
	localparam int STALL_LIMIT  = 500;
	// result passes through the input and result registers; keep some margin
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_ITEMS  = 125;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		action_t              action;
		logic [CHAR_W-1:0]    char_code;
		logic [COORD_W-1:0]   cell_x;
		logic [COORD_W-1:0]   cell_y;
		logic                 scroll_up;
		logic [COORD_W-1:0]   col_px;
		logic [COORD_W-1:0]   row_px;
	} console_result_t;

	class console_scoreboard;
		logic [COORD_W-1:0] width, height, cur_x, cur_y;
		console_result_t    expected_q[$];
		int mismatches, checked, draws, clears, scrolls, no_ops;

		function new();
			width      = RESET_WIDTH;
			height     = RESET_HEIGHT;
			cur_x      = CUR_ORIGIN;
			cur_y      = CUR_ORIGIN;
			mismatches = 0;
			checked    = 0;
			draws      = 0;
			clears     = 0;
			scrolls    = 0;
			no_ops     = 0;
		endfunction

		// set-1 make code -> ASCII, zero for keys with no glyph
		static function logic [CHAR_W-1:0] ascii_of(logic [CHAR_W-1:0] code);
			logic [CHAR_W-1:0] ch;
			case (code)
				7'h02: ch = "1";
				7'h03: ch = "2";
				7'h04: ch = "3";
				7'h05: ch = "4";
				7'h06: ch = "5";
				7'h07: ch = "6";
				7'h08: ch = "7";
				7'h09: ch = "8";
				7'h0A: ch = "9";
				7'h0B: ch = "0";
				7'h10: ch = "q";
				7'h11: ch = "w";
				7'h12: ch = "e";
				7'h13: ch = "r";
				7'h14: ch = "t";
				7'h15: ch = "y";
				7'h16: ch = "u";
				7'h17: ch = "i";
				7'h18: ch = "o";
				7'h19: ch = "p";
				7'h1E: ch = "a";
				7'h1F: ch = "s";
				7'h20: ch = "d";
				7'h21: ch = "f";
				7'h22: ch = "g";
				7'h23: ch = "h";
				7'h24: ch = "j";
				7'h25: ch = "k";
				7'h26: ch = "l";
				7'h2C: ch = "z";
				7'h2D: ch = "x";
				7'h2E: ch = "c";
				7'h2F: ch = "v";
				7'h30: ch = "b";
				7'h31: ch = "n";
				7'h32: ch = "m";
				7'h39: ch = " ";
				default: ch = '0;
			endcase
			return ch;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [COORD_W-1:0] value);
			if (idx == REG_SCREEN_WIDTH)
				width = value;
			else
				height = value;
		endfunction

		// advance the cursor for one accepted scancode and queue its result
		function void note_input(logic [CODE_W-1:0] code);
			console_result_t   r;
			logic [CHAR_W-1:0] ch;
			int                cols;
			bit                moved;
			r.action    = ACT_NONE;
			r.char_code = '0;
			r.cell_x    = '0;
			r.cell_y    = '0;
			r.scroll_up = 1'b0;
			moved       = 1'b0;
			ch          = ascii_of(code[CHAR_W-1:0]);
			if (code != '0 && !code[CODE_W-1]) begin
				if (code == CODE_BACKSPACE) begin
					if (cur_x == CUR_ORIGIN && cur_y == CUR_ORIGIN) begin
						// nothing left to erase
					end else if (cur_x > CUR_ORIGIN) begin
						cur_x    = cur_x - CELL_W;
						r.action = ACT_CLEAR;
						r.cell_x = cur_x;
						r.cell_y = cur_y;
					end else if (cur_y > CUR_ORIGIN) begin
						cur_y = cur_y - CELL_H;
						cols  = (width >= CUR_ORIGIN) ? (int'(width) - 50) / 24 : 0;
						// no full column: x stays put, line change still happens
						if (cols > 0)
							cur_x = COORD_W'(50 + (cols - 1) * 24);
						r.action = ACT_CLEAR;
						r.cell_x = cur_x;
						r.cell_y = cur_y;
					end
				end else begin
					if (code == CODE_ENTER) begin
						cur_x = CUR_ORIGIN;
						cur_y = cur_y + CELL_H;
						moved = 1'b1;
					end else if (ch != '0) begin
						// right edge wrap; compare without coordinate wrap
						if (int'(cur_x) + 24 > int'(width)) begin
							cur_x = CUR_ORIGIN;
							cur_y = cur_y + CELL_H;
						end
						r.action    = ACT_DRAW;
						r.char_code = ch;
						r.cell_x    = cur_x;
						r.cell_y    = cur_y;
						cur_x       = cur_x + CELL_W;
						moved       = 1'b1;
					end
					// one bottom check per item
					if (moved && int'(cur_y) + 36 > int'(height)) begin
						r.scroll_up = 1'b1;
						cur_y       = cur_y - CELL_H;
					end
				end
			end
			r.col_px = cur_x;
			r.row_px = cur_y;
			case (r.action)
				ACT_DRAW:  draws++;
				ACT_CLEAR: clears++;
				default:   no_ops++;
			endcase
			if (r.scroll_up)
				scrolls++;
			expected_q.push_back(r);
		endfunction

		function void check_result(console_result_t got);
			console_result_t want;
			bit              bad;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result act=%0d ch=%02h cell=(%0d,%0d) scr=%0d cur=(%0d,%0d)",
						$time, got.action, got.char_code, got.cell_x, got.cell_y,
						got.scroll_up, got.col_px, got.row_px);
				return;
			end
			want = expected_q.pop_front();
			bad  = (got.action    !== want.action)    ||
			       (got.char_code !== want.char_code) ||
			       (got.cell_x    !== want.cell_x)    ||
			       (got.cell_y    !== want.cell_y)    ||
			       (got.scroll_up !== want.scroll_up) ||
			       (got.col_px    !== want.col_px)    ||
			       (got.row_px    !== want.row_px);
			if (bad) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: mismatch #%0d", $time, mismatches);
					$display("  exp act=%0d ch=%02h cell=(%0d,%0d) scr=%0d cur=(%0d,%0d)",
						want.action, want.char_code, want.cell_x, want.cell_y,
						want.scroll_up, want.col_px, want.row_px);
					$display("  got act=%0d ch=%02h cell=(%0d,%0d) scr=%0d cur=(%0d,%0d)",
						got.action, got.char_code, got.cell_x, got.cell_y,
						got.scroll_up, got.col_px, got.row_px);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CODE_W-1:0]   scancode;
	logic                out_valid;
	logic                out_ready;
	action_t             action;
	logic [CHAR_W-1:0]   char_code;
	logic [COORD_W-1:0]  cell_x;
	logic [COORD_W-1:0]  cell_y;
	logic                scroll_up;
	logic [COORD_W-1:0]  cursor_col_px;
	logic [COORD_W-1:0]  cursor_row_px;
	logic                cfg_wr_en;
	cfg_reg_t            cfg_index;
	logic [COORD_W-1:0]  cfg_wdata;

	console_scoreboard sb = new();

	// idling control: rush turns off all gaps for the closing stretch,
	// the quiet flags give random stretches with no gaps on one side
	bit rush     = 1'b0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int settings_applied = 0;

	keyboard_text_console_cursor u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.scancode      (scancode),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.char_code     (char_code),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.scroll_up     (scroll_up),
		.cursor_col_px (cursor_col_px),
		.cursor_row_px (cursor_row_px),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: out_ready changes only at the falling edge. Stalls come in
	// bursts, absent during quiet stretches and the rush.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(0, 39) == 0)
					rx_quiet = !rx_quiet;
				if (!rush && !rx_quiet && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 11);
			end
		end
	end

	// Output monitor: every output transfer is checked at the rising edge,
	// seeing the values that stood before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{action, char_code, cell_x, cell_y, scroll_up,
				cursor_col_px, cursor_row_px});
	end

	// Watchdog: any transfer on either channel resets the count.
	initial begin : watchdog
		int stall;
		stall = 0;
		@(posedge arst_n);
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall = 0;
			else
				stall++;
		end
		$display("watchdog: %0d cycles without a transfer", STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// One scancode transfer. Called at a falling edge, returns at a falling
	// edge; in_valid stays high across back-to-back items.
	task automatic send_scancode(input logic [CODE_W-1:0] code);
		int gap;
		gap = 0;
		if (!rush) begin
			if ($urandom_range(0, 29) == 0)
				tx_quiet = !tx_quiet;
			if (!tx_quiet && $urandom_range(0, 4) == 0)
				gap = $urandom_range(1, 11);
		end
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		scancode = code;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(code);
		@(negedge clk);
	endtask

	task automatic send_codes(input logic [CODE_W-1:0] codes[$]);
		foreach (codes[k])
			send_scancode(codes[k]);
	endtask

	// sender stops until every predicted result has been seen and the
	// pipeline has had time to empty
	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [COORD_W-1:0] value);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		sb.set_reg(idx, value);
	endtask

	// screen registers are only touched with the block idle
	task automatic apply_setting(input int w, input int h);
		wait_drained();
		write_reg(REG_SCREEN_WIDTH, COORD_W'(w));
		write_reg(REG_SCREEN_HEIGHT, COORD_W'(h));
		cfg_wr_en = 1'b0;
		settings_applied++;
	endtask

	// Mostly typing (keys, Enter, Backspace) so the cursor walks across
	// lines and hits the bottom; the rest is releases, zero and raw bytes.
	function automatic logic [CODE_W-1:0] pick_scancode();
		int                roll;
		logic [CODE_W-1:0] c;
		roll = $urandom_range(0, 99);
		if (roll < 56) begin
			do
				c = CODE_W'($urandom_range(1, 8'h39));
			while (console_scoreboard::ascii_of(c[CHAR_W-1:0]) == '0);
		end else if (roll < 66) begin
			c = CODE_ENTER;
		end else if (roll < 80) begin
			c = CODE_BACKSPACE;
		end else if (roll < 88) begin
			c = CODE_W'(8'h80 | $urandom_range(0, 127));
		end else if (roll < 92) begin
			c = '0;
		end else begin
			c = CODE_W'($urandom_range(0, 255));
		end
		return c;
	endfunction

	task automatic run_random(input int count);
		int done;
		int run;
		done = 0;
		while (done < count) begin
			// occasional long run of backspaces to walk back over lines
			if ($urandom_range(0, 59) == 0) begin
				run = $urandom_range(5, 45);
				repeat (run) send_scancode(CODE_BACKSPACE);
				done += run;
			end else begin
				send_scancode(pick_scancode());
				done++;
			end
		end
	endtask

	initial begin : stimulus
		int phase_w[9];
		int phase_h[9];
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		scancode  = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_SCREEN_WIDTH;
		cfg_wdata = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, reset screen 1024x768: zero and release codes, extreme
		// bytes, backspace at the origin, unmapped keys, several mapped keys
		// and space, backspace mid-line, enter, backspace at line start back
		// to the last column, then a right-edge wrap.
		send_codes('{8'h00, 8'h80, 8'hFF, CODE_BACKSPACE, 8'h01, 8'h7F,
			8'h02, 8'h0B, 8'h10, 8'h32, 8'h39, CODE_BACKSPACE, 8'h9E,
			CODE_ENTER, CODE_BACKSPACE, 8'h26, 8'h1E});
		// Narrowest screen: wrap plus scroll on a key, scroll on enter,
		// backspace at line start with exactly one column.
		apply_setting(74, 86);
		send_codes('{8'h2C, CODE_ENTER, CODE_BACKSPACE, 8'h31, CODE_BACKSPACE});
		// Width below the origin: line change with x left alone.
		apply_setting(30, 200);
		send_codes('{CODE_ENTER, CODE_BACKSPACE});
		// Width with zero whole columns.
		apply_setting(60, 4095);
		send_codes('{8'h2E, CODE_BACKSPACE, CODE_BACKSPACE});

		// Random phases; phase 4 gets a random in-range screen and the
		// zero-size and sub-range screens exercise the corner arithmetic.
		phase_w = '{1024, 74, 4095, 4095, 0, 0, 60, 30, 240};
		phase_h = '{768, 4095, 86, 4095, 0, 0, 300, 122, 200};
		phase_w[4] = $urandom_range(74, 4095);
		phase_h[4] = $urandom_range(86, 4095);
		for (int p = 0; p < 9; p++) begin
			apply_setting(phase_w[p], phase_h[p]);
			// last phase runs both channels flat out
			if (p == 8)
				rush = 1'b1;
			if (p == 2) begin
				// sender holds off mid-phase until everything is back
				run_random(PHASE_ITEMS / 2);
				wait_drained();
				run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				run_random(PHASE_ITEMS);
			end
		end

		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		// any stray result in this window shows up as unexpected
		repeat (2 * DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d results over %0d screen settings: %0d draws, %0d clears, %0d no-ops",
			sb.checked, settings_applied + 1, sb.draws, sb.clears, sb.no_ops);
		$display("%0d scrolls, %0d mismatches, %0d results still outstanding",
			sb.scrolls, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/kbcon_pkg.sv
src/keyboard_text_console_cursor.sv
tb/sv/keyboard_text_console_cursor_tb.sv
